/* sv/fm_tone_sample_generator_core_assert.svh */
// Assertion helpers for the FM tone sample generator.
// Both expect clk and rst_n in scope; checks are off while in reset.
`ifndef FM_TONE_SAMPLE_GENERATOR_CORE_ASSERT_SVH
`define FM_TONE_SAMPLE_GENERATOR_CORE_ASSERT_SVH

// Same-cycle implication
`define FMTSG_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define FMTSG_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/fmtsg_pkg.sv */
`timescale 1ns / 1ps

package fmtsg_pkg;

  // Configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_CARRIER_STEP   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CARRIER_OFFSET = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SIGNAL_STEP    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SIGNAL_OFFSET  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DEVIATION      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_AMPLITUDE      = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_START_INDEX    = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_STOP_INDEX     = 3'd7;

  // Register file contents
  typedef struct packed {
    logic [31:0] carrier_step;
    logic [31:0] carrier_offset;
    logic [31:0] signal_step;
    logic [31:0] signal_offset;
    logic [31:0] deviation;
    logic [31:0] amplitude;
    logic [31:0] start_index;
    logic [31:0] stop_index;
  } fmtsg_cfg_t;

  localparam fmtsg_cfg_t CFG_RESET = '{
    carrier_step:   32'd0,
    carrier_offset: 32'd0,
    signal_step:    32'd4294967,
    signal_offset:  32'd0,
    deviation:      32'd2670177,
    amplitude:      32'd14654,
    start_index:    32'd0,
    stop_index:     32'd1
  };

  // Pi/2 in Q30
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  // Quarter-wave sine entry k, evaluated at elaboration only.
  // Taylor series in Q30, nine terms, truncating at each step.
  function automatic logic [31:0] qtab_entry(input int unsigned k,
                                             input int unsigned abits,
                                             input int unsigned tbits);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] p;
    logic [63:0] full;
    logic [63:0] val;
    x    = (HALF_PI_Q30 * 64'(k)) >> abits;
    x2   = (x * x) >> 30;
    term = x;
    sum  = x;
    for (int n = 1; n <= 8; n++) begin
      p = (term * x2) >> 30;
      case (n)
        1:       term = p / 6;
        2:       term = p / 20;
        3:       term = p / 42;
        4:       term = p / 72;
        5:       term = p / 110;
        6:       term = p / 156;
        7:       term = p / 210;
        default: term = p / 272;
      endcase
      if (n % 2 == 1) begin
        sum = (term > sum) ? 64'd0 : sum - term;
      end else begin
        sum = sum + term;
      end
    end
    full = 64'd1 << (tbits - 1);
    val  = (sum * full + (64'd1 << 29)) >> 30;
    if (val > full) begin
      val = full;
    end
    return val[31:0];
  endfunction

endpackage

/* sv/fmtsg_cfg_regs.sv */
`timescale 1ns / 1ps

module fmtsg_cfg_regs (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           wr_en,
  input  logic [fmtsg_pkg::CFG_IDX_W-1:0] wr_index,
  input  logic [31:0]                    wr_data,
  output fmtsg_pkg::fmtsg_cfg_t          cfg_r
);
  import fmtsg_pkg::*;

  fmtsg_cfg_t cfg_nxt;

  // Register write decode
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (wr_index)
        REG_CARRIER_STEP:   cfg_nxt.carrier_step   = wr_data;
        REG_CARRIER_OFFSET: cfg_nxt.carrier_offset = wr_data;
        REG_SIGNAL_STEP:    cfg_nxt.signal_step    = wr_data;
        REG_SIGNAL_OFFSET:  cfg_nxt.signal_offset  = wr_data;
        REG_DEVIATION:      cfg_nxt.deviation      = wr_data;
        REG_AMPLITUDE:      cfg_nxt.amplitude      = wr_data;
        REG_START_INDEX:    cfg_nxt.start_index    = wr_data;
        REG_STOP_INDEX:     cfg_nxt.stop_index     = wr_data;
        default:            cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

/* sv/fmtsg_phase.sv */
`timescale 1ns / 1ps

// Stages 1 and 2: window check and offset index, then both phase multiply-adds.
module fmtsg_phase (
  input  logic                  clk,
  input  logic                  en1,
  input  logic                  en2,
  input  fmtsg_pkg::fmtsg_cfg_t cfg,
  input  logic [31:0]           idx,
  output logic [31:0]           pc_r,
  output logic [31:0]           ps_r,
  output logic                  on_r
);
  import fmtsg_pkg::*;

  logic [31:0] n_r;
  logic [31:0] n_nxt;
  logic        on1_r;
  logic        on1_nxt;
  logic [31:0] pc_nxt;
  logic [31:0] ps_nxt;

  // Stage 1: window and index relative to start
  assign on1_nxt = (idx >= cfg.start_index) && (idx <= cfg.stop_index);
  assign n_nxt   = idx - cfg.start_index;

  // Stage 2: phase = n * step + offset, mod 2^32
  assign pc_nxt = n_r * cfg.carrier_step + cfg.carrier_offset;
  assign ps_nxt = n_r * cfg.signal_step + cfg.signal_offset;

  always_ff @(posedge clk) begin
    if (en1) begin
      n_r   <= n_nxt;
      on1_r <= on1_nxt;
    end
    if (en2) begin
      pc_r <= pc_nxt;
      ps_r <= ps_nxt;
      on_r <= on1_r;
    end
  end

endmodule

/* sv/fmtsg_qlut.sv */
`timescale 1ns / 1ps

// Quarter-wave sine lookup with quadrant fold, registered read.
module fmtsg_qlut #(
  parameter int ADDR_BITS = 10,
  parameter int TRIG_BITS = 16
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic [31:0]          phase,
  output logic [TRIG_BITS-1:0] mag_r,
  output logic                 neg_r
);
  import fmtsg_pkg::*;

  localparam int QLEN = (1 << ADDR_BITS) + 1;
  localparam int IW   = ADDR_BITS + 1;

  logic [TRIG_BITS-1:0] rom [QLEN];
  logic [1:0]           quad;
  logic [ADDR_BITS-1:0] addr_raw;
  logic [IW-1:0]        addr;

  // Constant table, one entry per quarter-wave step plus the end point
  for (genvar k = 0; k < QLEN; k++) begin : g_rom
    localparam logic [TRIG_BITS-1:0] ENT =
      TRIG_BITS'(qtab_entry(k, ADDR_BITS, TRIG_BITS));
    assign rom[k] = ENT;
  end

  // Odd quadrants run the table backwards
  assign quad     = phase[31:30];
  assign addr_raw = phase[29 -: ADDR_BITS];
  assign addr     = quad[0] ? (IW'(QLEN - 1) - {1'b0, addr_raw}) : {1'b0, addr_raw};

  always_ff @(posedge clk) begin
    if (en) begin
      mag_r <= rom[addr];
      neg_r <= quad[1];
    end
  end

endmodule

/* sv/fm_tone_sample_generator_core.sv */
`timescale 1ns / 1ps

// FM tone sample generator: each sample index word yields
// amplitude * cos(carrier phase + deviation * sin(signal phase)) in signed Q16.16,
// or zero with tone_on low outside the start..stop window. The datapath is a
// seven-stage pipeline (window check, phase multiply-add, sine table, deviation
// multiply, cosine table, amplitude multiply, saturate and gate), and one word is
// accepted every clock unless every stage is full under out_stall; the two sine
// tables are constant ROMs of 2^LUT_ADDR_BITS + 1 entries with registered reads.
// out_stall holds the whole pipeline only when every stage is full; empty
// stages keep absorbing words. cfg_ready is always high; write registers only
// while no word is in flight.
module fm_tone_sample_generator_core #(
  parameter int LUT_ADDR_BITS = 10,
  parameter int TRIG_BITS     = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [31:0]                     in_sample_index,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic signed [31:0]              out_sample_value,
  output logic                            out_tone_on,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [fmtsg_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                     cfg_data
);
  import fmtsg_pkg::*;

  localparam int NSTG = 7;
  localparam int PW   = 32 + TRIG_BITS;

  fmtsg_cfg_t cfg;

  logic [NSTG:1]        v_r;
  logic [NSTG:1]        v_nxt;
  logic [NSTG:1]        rdy;
  logic [NSTG-1:0]      vin;

  logic [31:0]          pc2;
  logic [31:0]          ps2;
  logic                 on2;
  logic [TRIG_BITS-1:0] s_mag;
  logic                 s_neg;
  logic [31:0]          pc3_r;
  logic                 on3_r;
  logic [PW-1:0]        prod_d;
  logic [PW-1:0]        d_sh;
  logic [31:0]          dphase;
  logic [31:0]          cph_r;
  logic [31:0]          cph_nxt;
  logic                 on4_r;
  logic [TRIG_BITS-1:0] c_mag;
  logic                 c_neg;
  logic                 on5_r;
  logic [PW-1:0]        prod_o;
  logic [32:0]          o_r;
  logic [32:0]          o_nxt;
  logic                 cneg6_r;
  logic                 on6_r;
  logic [31:0]          samp_r;
  logic [31:0]          samp_nxt;
  logic                 on7_r;

  // Register file
  assign cfg_ready = 1'b1;

  fmtsg_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg_r    (cfg)
  );

  // Pipeline flow: a stage loads when empty or when the next one moves on
  always_comb begin
    rdy[NSTG] = !v_r[NSTG] || !out_stall;
    for (int i = NSTG - 1; i >= 1; i--) begin
      rdy[i] = !v_r[i] || rdy[i+1];
    end
  end

  assign vin = {v_r[NSTG-1:1], in_valid};

  always_comb begin
    for (int i = 1; i <= NSTG; i++) begin
      v_nxt[i] = rdy[i] ? vin[i-1] : v_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  assign in_stall = !rdy[1];

  // Stages 1-2: window and phases
  fmtsg_phase u_phase (
    .clk  (clk),
    .en1  (rdy[1]),
    .en2  (rdy[2]),
    .cfg  (cfg),
    .idx  (in_sample_index),
    .pc_r (pc2),
    .ps_r (ps2),
    .on_r (on2)
  );

  // Stage 3: sine of the modulating phase
  fmtsg_qlut #(
    .ADDR_BITS (LUT_ADDR_BITS),
    .TRIG_BITS (TRIG_BITS)
  ) u_sin (
    .clk   (clk),
    .en    (rdy[3]),
    .phase (ps2),
    .mag_r (s_mag),
    .neg_r (s_neg)
  );

  always_ff @(posedge clk) begin
    if (rdy[3]) begin
      pc3_r <= pc2;
      on3_r <= on2;
    end
  end

  // Stage 4: signed deviation added to carrier, shifted a quarter turn for cosine
  assign prod_d  = PW'(cfg.deviation) * PW'(s_mag);
  assign d_sh    = prod_d >> (TRIG_BITS - 9);
  assign dphase  = s_neg ? (32'd0 - d_sh[31:0]) : d_sh[31:0];
  assign cph_nxt = pc3_r + dphase + 32'h4000_0000;

  always_ff @(posedge clk) begin
    if (rdy[4]) begin
      cph_r <= cph_nxt;
      on4_r <= on3_r;
    end
  end

  // Stage 5: cosine of the total phase
  fmtsg_qlut #(
    .ADDR_BITS (LUT_ADDR_BITS),
    .TRIG_BITS (TRIG_BITS)
  ) u_cos (
    .clk   (clk),
    .en    (rdy[5]),
    .phase (cph_r),
    .mag_r (c_mag),
    .neg_r (c_neg)
  );

  always_ff @(posedge clk) begin
    if (rdy[5]) begin
      on5_r <= on4_r;
    end
  end

  // Stage 6: amplitude scaling
  assign prod_o = PW'(cfg.amplitude) * PW'(c_mag);
  assign o_nxt  = 33'(prod_o >> (TRIG_BITS - 1));

  always_ff @(posedge clk) begin
    if (rdy[6]) begin
      o_r     <= o_nxt;
      cneg6_r <= c_neg;
      on6_r   <= on5_r;
    end
  end

  // Stage 7: saturate, apply sign, gate outside the window
  always_comb begin
    if (!on6_r) begin
      samp_nxt = 32'd0;
    end else if (cneg6_r) begin
      samp_nxt = (o_r > 33'h0_8000_0000) ? 32'h8000_0000 : (32'd0 - o_r[31:0]);
    end else begin
      samp_nxt = (o_r > 33'h0_7FFF_FFFF) ? 32'h7FFF_FFFF : o_r[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[NSTG]) begin
      samp_r <= samp_nxt;
      on7_r  <= on6_r;
    end
  end

  assign out_valid        = v_r[NSTG];
  assign out_sample_value = samp_r;
  assign out_tone_on      = on7_r;

  // Checks
  `include "fm_tone_sample_generator_core_assert.svh"

  `FMTSG_ASSERT_IMP(a_gated_zero, out_valid && !out_tone_on, ~|out_sample_value, "gated word not zero")
  `FMTSG_ASSERT_IMP(a_stall_full, in_stall, (&v_r) && out_stall, "input stalled with a free stage")
  `FMTSG_ASSERT_NXT(a_stage_hold, v_r[3] && !rdy[3], v_r[3], "held stage lost its word")

endmodule
